@@ design/swerm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerm_pkg
// Shared types and constants of the sliding-window event rate meter.
// ----------------------------------------------------------------------------
package swerm_pkg;

  localparam logic [31:0] WINDOW_RESET = 32'd4000000;
  localparam logic [27:0] US_PER_S_Q8  = 28'd256000000;
  localparam logic [36:0] RATE_MAX     = {37{1'b1}};
  localparam logic        REQ_ARRIVAL  = 1'b0;
  localparam logic        REQ_QUERY    = 1'b1;
  localparam logic [0:0]  REG_WINDOW   = 1'd0;

  typedef struct packed {
    logic        req_type;
    logic [63:0] time_us;
  } req_t;

  typedef struct packed {
    logic [9:0]  count_in_window;
    logic [36:0] rate_q8;
    logic [63:0] total_events;
  } resp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_EXP_RD,
    ST_EXP_WAIT,
    ST_EXP_CHK,
    ST_NEW_RD,
    ST_NEW_WAIT,
    ST_MUL,
    ST_DIV,
    ST_DONE,
    ST_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture request
    logic write;      // store arrival stamp
    logic rd_new;     // read ring at newest slot
    logic latch_old;  // capture oldest stamp
    logic drop;       // advance read pointer
    logic mul;        // form dividend and span
    logic div_step;
    logic finish;     // form result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_query;
    logic empty;
    logic expire;     // oldest stamp below limit
    logic div_done;
  } stat_t;

endpackage

@@ design/swerm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerm_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module swerm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/swerm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerm_ctrl
// Sequencer for arrival, expiry walk, rate division and result hand-off.
// ----------------------------------------------------------------------------
module swerm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  swerm_pkg::stat_t  stat,
  output swerm_pkg::cmd_t   cmd
);

  swerm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swerm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      swerm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = swerm_pkg::ST_WRITE;
        end
      end
      swerm_pkg::ST_WRITE: begin
        if (stat.is_query) begin
          state_next = swerm_pkg::ST_EXP_RD;
        end else begin
          cmd.write  = 1'b1;
          state_next = swerm_pkg::ST_IDLE;
        end
      end
      swerm_pkg::ST_EXP_RD: begin
        state_next = stat.empty ? swerm_pkg::ST_DONE : swerm_pkg::ST_EXP_WAIT;
      end
      swerm_pkg::ST_EXP_WAIT: begin
        cmd.latch_old = 1'b1;
        state_next    = swerm_pkg::ST_EXP_CHK;
      end
      swerm_pkg::ST_EXP_CHK: begin
        // Drop one expired stamp per pass and reread the next one.
        if (stat.expire) begin
          cmd.drop   = 1'b1;
          state_next = swerm_pkg::ST_EXP_RD;
        end else begin
          state_next = swerm_pkg::ST_NEW_RD;
        end
      end
      swerm_pkg::ST_NEW_RD: begin
        cmd.rd_new = 1'b1;
        state_next = swerm_pkg::ST_NEW_WAIT;
      end
      swerm_pkg::ST_NEW_WAIT: begin
        // Hold the newest slot on the port so the read data stays put.
        cmd.rd_new = 1'b1;
        state_next = swerm_pkg::ST_MUL;
      end
      swerm_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = swerm_pkg::ST_DIV;
      end
      swerm_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = swerm_pkg::ST_DONE;
        end
      end
      swerm_pkg::ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = swerm_pkg::ST_OUT;
      end
      swerm_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = swerm_pkg::ST_IDLE;
        end
      end
      default: state_next = swerm_pkg::ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == swerm_pkg::ST_OUT && !out_ready) |=> state == swerm_pkg::ST_OUT)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (rst)
    cmd.drop |-> (!stat.empty && stat.expire))
    else $error("drop from empty ring");
`endif

endmodule

@@ design/swerm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swerm_dp
// Stamp ring, pointers, totals and the bit-serial rate divider.
// ----------------------------------------------------------------------------
module swerm_dp #(
  parameter int RING_DEPTH = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  swerm_pkg::cmd_t    cmd,
  output swerm_pkg::stat_t   stat,
  input  swerm_pkg::req_t    req,
  input  logic [31:0]        window_us,
  output swerm_pkg::resp_t   resp
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int NW = CW + 28;  // dividend width
  localparam int DW = 64;
  localparam int KW = $clog2(NW + 1);
  localparam logic [AW-1:0] LAST   = AW'(RING_DEPTH - 1);
  localparam logic [CW-1:0] DEPTHC = CW'(RING_DEPTH);

  logic [AW-1:0] rd_ptr, wr_ptr, wr_ptr_inc, rd_ptr_inc, addr;
  logic          full, empty;
  logic [63:0]   total;
  swerm_pkg::req_t held;
  logic [63:0]   rdata, oldest, span;
  logic [CW-1:0] count;
  logic [NW-1:0] quo;
  logic [DW:0]   rem;
  logic [KW-1:0] bits_left;
  logic [DW+1:0] trial;

  assign wr_ptr_inc = (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
  assign empty = !full && (rd_ptr == wr_ptr);

  always_comb begin
    if (full) begin
      count = DEPTHC;
    end else if (rd_ptr <= wr_ptr) begin
      count = CW'(wr_ptr - rd_ptr);
    end else begin
      count = DEPTHC - CW'(rd_ptr - wr_ptr);
    end
  end

  always_comb begin
    priority if (cmd.write) begin
      addr = wr_ptr;
    end else if (cmd.rd_new) begin
      addr = (wr_ptr == '0) ? LAST : wr_ptr - 1'b1;
    end else begin
      addr = rd_ptr;
    end
  end

  swerm_ram #(.WIDTH(64), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (cmd.write),
    .addr  (addr),
    .wdata (held.time_us),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      full   <= 1'b0;
      total  <= '0;
    end else if (cmd.write) begin
      // A full ring overwrites its oldest slot, so both pointers advance.
      if (full) begin
        rd_ptr <= rd_ptr_inc;
      end
      wr_ptr <= wr_ptr_inc;
      full   <= full || (wr_ptr_inc == rd_ptr);
      total  <= total + 64'd1;
    end else if (cmd.drop) begin
      rd_ptr <= rd_ptr_inc;
      full   <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held <= req;
    end
    if (cmd.latch_old) begin
      oldest <= rdata;
    end
  end

  assign stat.is_query = (held.req_type == swerm_pkg::REQ_QUERY);
  assign stat.empty    = empty;
  assign stat.expire   = (held.time_us >= {32'd0, window_us})
                      && (oldest < held.time_us - {32'd0, window_us});

  // Restoring divider, one quotient bit per cycle.
  assign trial = {rem[DW:0], quo[NW-1]} - {2'b00, span};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      span      <= rdata - oldest;
      quo       <= NW'(count) * NW'(swerm_pkg::US_PER_S_Q8);
      rem       <= '0;
      bits_left <= KW'(NW);
    end else if (cmd.div_step && bits_left != '0) begin
      if (!trial[DW+1]) begin
        rem <= trial[DW:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= {rem[DW-1:0], quo[NW-1]};
        quo <= {quo[NW-2:0], 1'b0};
      end
      bits_left <= bits_left - 1'b1;
    end
  end

  assign stat.div_done = (bits_left == '0);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      resp.count_in_window <= 10'(count);
      resp.total_events    <= total;
      if (empty || span == '0) begin
        resp.rate_q8 <= '0;
      end else if (|(quo >> 37)) begin
        resp.rate_q8 <= swerm_pkg::RATE_MAX;
      end else begin
        resp.rate_q8 <= 37'(quo);
      end
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst) full |-> rd_ptr == wr_ptr)
    else $error("full ring with split pointers");
  assert property (@(posedge clk) disable iff (rst)
    cmd.write |=> total == $past(total) + 64'd1)
    else $error("total not bumped");
  assert property (@(posedge clk) disable iff (rst)
    cmd.drop |=> !full)
    else $error("full after drop");
`endif

endmodule

@@ design/sliding_window_event_rate_meter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_event_rate_meter
// Ring of event stamps with windowed expiry and events-per-second report.
// ----------------------------------------------------------------------------
// An arrival is accepted and then written to the ring. A query walks the
// stamps that expire, then forms the rate and hands off the result: the expiry
// walk reads one stamp at a time through the single ring port, and the rate
// comes from a restoring divider that yields one quotient bit per cycle over a
// 38-bit dividend. One item is in work at a time.
// window_us sits at byte address 0 of the register port.
module sliding_window_event_rate_meter #(
  parameter int RING_DEPTH = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  swerm_pkg::req_t    in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output swerm_pkg::resp_t   out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  swerm_pkg::cmd_t  cmd;
  swerm_pkg::stat_t stat;
  logic [31:0]      window_us;

  assign pready = 1'b1;
  assign prdata = (paddr[1:1] == swerm_pkg::REG_WINDOW) ? window_us : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_us <= swerm_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && paddr[1:1] == swerm_pkg::REG_WINDOW) begin
      window_us <= pwdata;
    end
  end

  swerm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  swerm_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (in_data),
    .window_us (window_us),
    .resp      (out_data)
  );

endmodule

@@ verif/tb_sliding_window_event_rate_meter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_event_rate_meter
// Self-checking bench for the sliding-window event rate meter.
// ----------------------------------------------------------------------------
// A directed table (extremes, early query, zero window, zero span, stamps out
// of order) runs first, then random phases under several window settings:
// mostly rising stamps with random queries, plus noise with random 64-bit
// times. One phase fills the ring past its depth. Query results are compared
// field by field against table values or an in-bench ring and divider model.
// ----------------------------------------------------------------------------
module tb_sliding_window_event_rate_meter;

  localparam int DEPTH      = 512;
  localparam int STALL_MAX  = 20000;
  localparam int DRAIN_WAIT = 20;

  typedef enum int {ROW_ARR, ROW_QRY, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [63:0] t;
    bit          typed;
    logic [9:0]  cnt;
    logic [36:0] rate;
    logic [63:0] tot;
  } row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  swerm_pkg::req_t  in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b1;
  swerm_pkg::resp_t out_data;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [1:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  sliding_window_event_rate_meter #(.RING_DEPTH(DEPTH)) dut (.*);

  always #5 clk = ~clk;

  // Bench copy of the meter state.
  logic [63:0] stamps [DEPTH];
  int unsigned rd_ptr, wr_ptr;
  bit          full_q;
  logic [63:0] arrivals_seen;
  logic [31:0] window_q;

  swerm_pkg::resp_t pending_rates[$];
  int    mismatches = 0;
  int    queries_checked = 0;
  int    arrivals_sent = 0;
  int    windows_used = 0;
  bit    idle_en = 1'b1;
  int    idle_cycles = 0;
  logic [63:0] now_us;

  function automatic int unsigned slot_after(int unsigned p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  function automatic bit ring_is_empty();
    return !full_q && rd_ptr == wr_ptr;
  endfunction

  task automatic meter_update(input swerm_pkg::req_t r, output bit has,
                              output swerm_pkg::resp_t o);
    logic [63:0] limit, oldest, newest, span, prod, q;
    int unsigned held, last;
    has = 1'b0;
    o = '0;
    if (r.req_type == swerm_pkg::REQ_ARRIVAL) begin
      if (full_q) begin
        rd_ptr = slot_after(rd_ptr);
        full_q = 1'b0;
      end
      stamps[wr_ptr] = r.time_us;
      wr_ptr = slot_after(wr_ptr);
      if (wr_ptr == rd_ptr) full_q = 1'b1;
      arrivals_seen = arrivals_seen + 64'd1;
      return;
    end
    if (r.time_us >= {32'd0, window_q}) begin
      limit = r.time_us - {32'd0, window_q};
      while (!ring_is_empty() && stamps[rd_ptr] < limit) begin
        rd_ptr = slot_after(rd_ptr);
        full_q = 1'b0;
      end
    end
    if (full_q) held = DEPTH;
    else if (rd_ptr <= wr_ptr) held = wr_ptr - rd_ptr;
    else held = DEPTH - (rd_ptr - wr_ptr);
    q = '0;
    if (!ring_is_empty()) begin
      last = (wr_ptr == 0) ? DEPTH - 1 : wr_ptr - 1;
      oldest = stamps[rd_ptr];
      newest = stamps[last];
      span = newest - oldest;
      if (span != 0) begin
        prod = 64'(held) * 64'(swerm_pkg::US_PER_S_Q8);
        q = prod / span;
        if (q > 64'(swerm_pkg::RATE_MAX)) q = 64'(swerm_pkg::RATE_MAX);
      end
    end
    has = 1'b1;
    o.count_in_window = held[9:0];
    o.rate_q8 = q[36:0];
    o.total_events = arrivals_seen;
  endtask

  // Present one item, hold it until the transfer, then update the model.
  task automatic send_item(input logic kind, input logic [63:0] t, input bit typed,
                           input swerm_pkg::resp_t typed_resp);
    swerm_pkg::req_t  r;
    bit               has;
    swerm_pkg::resp_t o;
    r.req_type = kind;
    r.time_us = t;
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    meter_update(r, has, o);
    if (has) pending_rates.push_back(typed ? typed_resp : o);
    if (kind == swerm_pkg::REQ_ARRIVAL) arrivals_sent++;
  endtask

  task automatic sender_gap();
    int n;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_window(input logic [31:0] v);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 2'(swerm_pkg::REG_WINDOW * 4);
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    window_q = v;
    windows_used++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Result side: random stall bursts.
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    swerm_pkg::resp_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_rates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: count=%0d rate=%0d total=%0d",
                   out_data.count_in_window, out_data.rate_q8, out_data.total_events);
      end else begin
        e = pending_rates.pop_front();
        queries_checked++;
        if (out_data.count_in_window !== e.count_in_window ||
            out_data.rate_q8 !== e.rate_q8 ||
            out_data.total_events !== e.total_events) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: count exp %0d got %0d, rate exp %0d got %0d,",
                      " total exp %0d got %0d"},
                     e.count_in_window, out_data.count_in_window, e.rate_q8,
                     out_data.rate_q8, e.total_events, out_data.total_events);
        end
      end
    end
  end

  // Watchdog: cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  row_t rows[$];

  task automatic add_row(input row_kind_t k, input logic [63:0] t, input bit typed = 0,
                         input logic [9:0] c = 0, input logic [36:0] r = 0,
                         input logic [63:0] tot = 0);
    row_t x;
    x.kind = k; x.t = t; x.typed = typed; x.cnt = c; x.rate = r; x.tot = tot;
    rows.push_back(x);
  endtask

  task automatic random_phase(input int items, input int query_pct);
    logic [63:0] t;
    logic        kind;
    for (int i = 0; i < items; i++) begin
      sender_gap();
      if ($urandom_range(0, 99) < 15) begin
        t = {$urandom, $urandom};
        kind = 1'($urandom_range(0, 1));
      end else begin
        now_us = now_us +
                 64'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 2000 : 40));
        t = now_us;
        kind = ($urandom_range(0, 99) < query_pct) ? swerm_pkg::REQ_QUERY
                                                     : swerm_pkg::REQ_ARRIVAL;
      end
      send_item(kind, t, 1'b0, '0);
    end
  endtask

  initial begin
    swerm_pkg::resp_t tr;
    logic [63:0] ones;
    ones = '1;
    rd_ptr = 0; wr_ptr = 0; full_q = 0; arrivals_seen = 0;
    window_q = swerm_pkg::WINDOW_RESET;
    now_us = 64'd100000;

    add_row(ROW_QRY, 0, 1, 0, 0, 0);
    add_row(ROW_ARR, 0);
    add_row(ROW_QRY, 0, 1, 1, 0, 1);                 // zero span
    add_row(ROW_ARR, 100);
    add_row(ROW_QRY, 100, 1, 2, 37'd5120000, 2);
    add_row(ROW_ARR, ones);
    add_row(ROW_QRY, ones, 1, 1, 0, 3);              // old stamps expire
    add_row(ROW_ARR, 0);                             // out of order, span wraps to 1
    add_row(ROW_QRY, 5, 1, 2, 37'd512000000, 4);     // early query
    add_row(ROW_QRY, ones);
    add_row(ROW_CFG, 0);                             // zero window
    add_row(ROW_QRY, 1);
    add_row(ROW_ARR, 7);
    add_row(ROW_QRY, 7);
    add_row(ROW_QRY, 8);
    add_row(ROW_CFG, 32'hFFFF_FFFF);
    add_row(ROW_ARR, 10);
    add_row(ROW_QRY, 20);
    add_row(ROW_QRY, ones);
    add_row(ROW_CFG, 1);
    add_row(ROW_ARR, ones - 1);
    add_row(ROW_QRY, ones);
    add_row(ROW_CFG, swerm_pkg::WINDOW_RESET);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_window(rows[i].t[31:0]);
      end else begin
        tr.count_in_window = rows[i].cnt;
        tr.rate_q8 = rows[i].rate;
        tr.total_events = rows[i].tot;
        send_item(rows[i].kind == ROW_QRY ? swerm_pkg::REQ_QUERY : swerm_pkg::REQ_ARRIVAL,
                  rows[i].t, rows[i].typed, tr);
      end
    end

    // Fill the ring past its depth, then sweep window settings.
    write_window(32'hFFFF_FFFF);
    random_phase(620, 3);
    write_window(1);
    random_phase(90, 30);
    write_window($urandom_range(100, 5000));
    random_phase(90, 30);
    write_window(0);
    random_phase(80, 30);
    write_window(swerm_pkg::WINDOW_RESET);
    random_phase(90, 25);
    write_window($urandom_range(50, 20000));
    idle_en = 1'b0;
    random_phase(90, 30);

    drain();
    $display("covered %0d arrivals and %0d checked queries over %0d window writes",
             arrivals_sent, queries_checked, windows_used);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
